@@ hdl/tds_pkg.sv @@
// Shared types, constants and helpers for the tridiagonal solver.
// No dependencies; every other file imports this package.
package tds_pkg;

    localparam int DATA_W        = 32;
    localparam int IDX_W         = 6;
    localparam int MAX_ROWS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef logic signed [DATA_W-1:0] q_t;

    typedef struct packed {
        logic ovf;
        q_t   val;
    } clamp_t;

    // Clamp a 65-bit signed value to the 32-bit range.
    function automatic clamp_t clamp65(input logic signed [64:0] v);
        clamp_t r;
        if (v > 65'sd2147483647) begin
            r.ovf = 1'b1;
            r.val = S32_MAX;
        end
        else if (v < -65'sd2147483648) begin
            r.ovf = 1'b1;
            r.val = S32_MIN;
        end
        else begin
            r.ovf = 1'b0;
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

    typedef struct packed {
        logic done;
        logic ovf;
        logic zero_div;
        q_t   quo;
    } div_res_t;

endpackage

@@ hdl/tds_if.sv @@
// Channel interfaces for row input and solution output.
// Depends on tds_pkg.
interface tds_row_if
    import tds_pkg::*;
();
    logic valid;
    logic ready;
    q_t   sub_diag;
    q_t   main_diag;
    q_t   super_diag;
    q_t   rhs_value;
    logic last_row;

    modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                    input ready);
    modport sink   (input valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                    output ready);
endinterface

interface tds_sol_if
    import tds_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] row_index;
    q_t               solution;
    logic             last_out;
    logic             singular;
    logic             saturated;

    modport source (output valid, row_index, solution, last_out, singular, saturated,
                    input ready);
    modport sink   (input valid, row_index, solution, last_out, singular, saturated,
                    output ready);
endinterface

@@ hdl/tridiagonal_system_solver.sv @@
// Tridiagonal system solver (Thomas algorithm) in signed fixed point, Q16.16 at
// the default FRAC_BITS. Rows are taken one at a time; each row waits on the
// bit-serial divider pair that forms c'[n] and v'[n] in parallel. The last row
// then runs back substitution (read, multiply, subtract per row), writing the
// solutions over the stored right-hand side, and then emits one result per row
// from the last row down to row 0, each read, loaded and held until sols.ready.
// No clearing pass after reset. Depends on tds_pkg, tds_if, tds_divider, tds_store.
module tridiagonal_system_solver
    import tds_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input logic       clk,
    input logic       rst_n,
    tds_row_if.sink   rows,
    tds_sol_if.source sols
);
    localparam int AW = $clog2(MAX_ROWS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SUB   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_BRD   = 4'd4;
    localparam logic [3:0] S_BMUL  = 4'd5;
    localparam logic [3:0] S_BSUB  = 4'd6;
    localparam logic [3:0] S_ERD   = 4'd7;
    localparam logic [3:0] S_ELOAD = 4'd8;
    localparam logic [3:0] S_EOUT  = 4'd9;
    localparam logic [3:0] S_DGO   = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] n_reg, n_next;
    logic          sing_reg, sing_next;
    logic          ovf_reg, ovf_next;
    logic          last_reg, last_next;

    q_t a_reg, b_reg, c_reg, v_reg;
    q_t cprev_reg, vprev_reg;
    q_t pivot_reg, num_reg;
    q_t x_reg;
    logic signed [63:0] prodc_reg, prodv_reg;

    q_t                sol_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              lo_reg, so_reg, vo_reg;

    logic     div_start;
    div_res_t dsup, drhs;

    logic    we_super, we_rhs, re;
    logic [AW-1:0] waddr, raddr;
    q_t      wsuper, wrhs, rsuper, rrhs;

    logic   accept;
    clamp_t piv_c, num_c, x_c;

    tds_divider #(.FRAC_BITS(FRAC_BITS)) u_div_super (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(c_reg), .den(pivot_reg), .res(dsup)
    );

    tds_divider #(.FRAC_BITS(FRAC_BITS)) u_div_rhs (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(num_reg), .den(pivot_reg), .res(drhs)
    );

    tds_store #(.MAX_ROWS(MAX_ROWS)) u_store (
        .clk(clk), .we_super(we_super), .we_rhs(we_rhs), .waddr(waddr),
        .wsuper(wsuper), .wrhs(wrhs), .re(re), .raddr(raddr),
        .rsuper(rsuper), .rrhs(rrhs)
    );

    assign accept         = rows.valid && rows.ready;
    assign rows.ready     = (state_reg == S_IDLE);
    // Pivot and numerator are registered by now.
    assign div_start      = (state_reg == S_DGO);
    assign sols.valid     = (state_reg == S_EOUT);
    assign sols.row_index = idx_reg;
    assign sols.solution  = sol_reg;
    assign sols.last_out  = lo_reg;
    assign sols.singular  = so_reg;
    assign sols.saturated = vo_reg;

    always_comb
    begin
        piv_c = clamp65(65'(b_reg) - 65'(prodc_reg >>> FRAC_BITS));
        num_c = clamp65(65'(v_reg) - 65'(prodv_reg >>> FRAC_BITS));
        x_c   = clamp65(65'(rrhs) - 65'(prodc_reg >>> FRAC_BITS));
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        sing_next  = sing_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        we_super   = 1'b0;
        we_rhs     = 1'b0;
        waddr      = n_reg;
        wsuper     = dsup.quo;
        wrhs       = x_c.val;
        re         = 1'b0;
        raddr      = n_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next  = rows.last_row || (k_reg == AW'(MAX_ROWS - 1));
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SUB;
            end
            S_SUB:
            begin
                if (k_reg != '0)
                begin
                    ovf_next = ovf_reg | piv_c.ovf | num_c.ovf;
                end
                state_next = S_DGO;
            end
            S_DGO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (drhs.done)
                begin
                    we_super  = 1'b1;
                    we_rhs    = 1'b1;
                    waddr     = k_reg;
                    wsuper    = last_reg ? '0 : dsup.quo;
                    wrhs      = drhs.quo;
                    sing_next = sing_reg | drhs.zero_div;
                    ovf_next  = ovf_reg | drhs.ovf | (dsup.ovf & ~last_reg);
                    if (!last_reg)
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (k_reg == '0)
                    begin
                        n_next     = '0;
                        state_next = S_ERD;
                    end
                    else
                    begin
                        n_next     = k_reg - 1'b1;
                        state_next = S_BRD;
                    end
                end
            end
            S_BRD:
            begin
                re         = 1'b1;
                state_next = S_BMUL;
            end
            S_BMUL:
            begin
                state_next = S_BSUB;
            end
            S_BSUB:
            begin
                we_rhs   = 1'b1;
                ovf_next = ovf_reg | x_c.ovf;
                if (n_reg == '0)
                begin
                    n_next     = k_reg;
                    state_next = S_ERD;
                end
                else
                begin
                    n_next     = n_reg - 1'b1;
                    state_next = S_BRD;
                end
            end
            S_ERD:
            begin
                re         = 1'b1;
                state_next = S_ELOAD;
            end
            S_ELOAD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (sols.ready)
                begin
                    if (n_reg == '0)
                    begin
                        k_next     = '0;
                        sing_next  = 1'b0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        n_next     = n_reg - 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
            sing_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            sing_reg  <= sing_next;
            ovf_reg   <= ovf_next;
            last_reg  <= last_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= rows.sub_diag;
            b_reg <= rows.main_diag;
            c_reg <= rows.super_diag;
            v_reg <= rows.rhs_value;
        end
        if (state_reg == S_MUL)
        begin
            prodc_reg <= a_reg * cprev_reg;
            prodv_reg <= a_reg * vprev_reg;
        end
        if (state_reg == S_BMUL)
        begin
            prodc_reg <= rsuper * x_reg;
        end
        if (state_reg == S_SUB)
        begin
            pivot_reg <= (k_reg == '0) ? b_reg : piv_c.val;
            num_reg   <= (k_reg == '0) ? v_reg : num_c.val;
        end
        if (state_reg == S_DIV && drhs.done)
        begin
            cprev_reg <= dsup.quo;
            vprev_reg <= drhs.quo;
            x_reg     <= drhs.quo;
        end
        if (state_reg == S_BSUB)
        begin
            x_reg <= x_c.val;
        end
        if (state_reg == S_ELOAD)
        begin
            sol_reg <= rrhs;
            idx_reg <= IDX_W'(n_reg);
            lo_reg  <= (n_reg == '0);
            so_reg  <= sing_reg;
            vo_reg  <= ovf_reg;
        end
    end

    a_last_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        sols.valid && sols.last_out |-> sols.row_index == '0)
        else $error("last_out on a nonzero row");

    a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && rows.ready |=> !rows.ready)
        else $error("second row taken while one is in work");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dsup.done == drhs.done)
        else $error("dividers out of step");

    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        sols.valid && sols.ready |=> !sols.valid)
        else $error("result repeated without a new read");

endmodule

@@ hdl/tds_divider.sv @@
// Restoring radix-2 divider: (num * 2^FRAC_BITS) / den, truncated, clamped.
// Depends on tds_pkg.
module tds_divider
    import tds_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  q_t       num,
    input  q_t       den,
    output div_res_t res
);
    localparam int DW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DW-1:0]        quo_reg, quo_next;
    logic [DATA_W-1:0]    dmag_reg, dmag_next;
    logic                 neg_reg, neg_next;
    logic                 numneg_reg, numneg_next;
    logic                 zero_reg, zero_next;

    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      trial;
    logic [DATA_W-1:0]    nmag;
    logic [DATA_W-1:0]    dmag_in;

    always_comb
    begin
        nmag      = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
        dmag_in   = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
        shifted   = {rem_reg, quo_reg[DW-1]};
        trial     = shifted - {1'b0, dmag_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        numneg_next = numneg_reg;
        zero_next = zero_reg;
        if (start)
        begin
            numneg_next = num[DATA_W-1];
            neg_next    = num[DATA_W-1] ^ den[DATA_W-1];
            dmag_next   = dmag_in;
            rem_next    = '0;
            quo_next    = {nmag, {FRAC_BITS{1'b0}}};
            cnt_next    = CW'(DW);
            if (den == '0)
            begin
                zero_next = 1'b1;
                done_next = 1'b1;
            end
            else
            begin
                zero_next = 1'b0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dmag_reg   <= dmag_next;
        neg_reg    <= neg_next;
        numneg_reg <= numneg_next;
        zero_reg   <= zero_next;
    end

    // Sign and clamp the magnitude quotient.
    always_comb
    begin
        res.done     = done_reg;
        res.zero_div = zero_reg;
        res.ovf      = 1'b0;
        res.quo      = S32_MAX;
        if (zero_reg)
        begin
            res.quo = numneg_reg ? S32_MIN : S32_MAX;
        end
        else if (neg_reg)
        begin
            if (quo_reg > DW'(64'h8000_0000))
            begin
                res.ovf = 1'b1;
                res.quo = S32_MIN;
            end
            else
            begin
                res.quo = DATA_W'(-quo_reg[DATA_W-1:0]);
            end
        end
        else
        begin
            if (quo_reg > DW'(64'h7FFF_FFFF))
            begin
                res.ovf = 1'b1;
                res.quo = S32_MAX;
            end
            else
            begin
                res.quo = quo_reg[DATA_W-1:0];
            end
        end
    end

endmodule

@@ hdl/tds_store.sv @@
// Row store: modified super-diagonal and right-hand side memories.
// One write and one registered read port each. Depends on tds_pkg.
module tds_store
    import tds_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
)(
    input  logic                        clk,
    input  logic                        we_super,
    input  logic                        we_rhs,
    input  logic [$clog2(MAX_ROWS)-1:0] waddr,
    input  q_t                          wsuper,
    input  q_t                          wrhs,
    input  logic                        re,
    input  logic [$clog2(MAX_ROWS)-1:0] raddr,
    output q_t                          rsuper,
    output q_t                          rrhs
);
    q_t super_mem [MAX_ROWS];
    q_t rhs_mem   [MAX_ROWS];
    q_t rsuper_reg;
    q_t rrhs_reg;

    always_ff @(posedge clk)
    begin
        if (we_super)
        begin
            super_mem[waddr] <= wsuper;
        end
        if (we_rhs)
        begin
            rhs_mem[waddr] <= wrhs;
        end
        if (re)
        begin
            rsuper_reg <= super_mem[raddr];
            rrhs_reg   <= rhs_mem[raddr];
        end
    end

    assign rsuper = rsuper_reg;
    assign rrhs   = rrhs_reg;

endmodule

@@ bench/tds_checker.sv @@
// Solution checker for the tridiagonal solver: predicts every solution from the
// accepted rows and compares it with what the solver emits.
// Depends on tds_pkg and tds_if.
module tds_checker
    import tds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tds_row_if   rows,
    tds_sol_if   sols,
    output int   errors,
    output int   pending
);

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam int     DEPTH = MAX_ROWS_DEF;
    localparam int     FRAC  = FRAC_BITS_DEF;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        q_t               solution;
        logic             last_out;
        logic             singular;
        logic             saturated;
    } solution_t;

    solution_t expected_solutions[$];
    longint    mod_super[DEPTH];
    longint    mod_rhs[DEPTH];
    int        rows_taken;
    bit        pivot_zero_seen;
    bit        clamp_seen;

    function automatic longint clamp_q(longint v);
        if (v > Q_MAX)
        begin
            clamp_seen = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            clamp_seen = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic longint fx_mul(longint p, longint q);
        return (p * q) >>> FRAC;
    endfunction

    function automatic longint fx_div(longint n, longint d);
        if (d == 0)
        begin
            pivot_zero_seen = 1'b1;
            return (n >= 0) ? Q_MAX : Q_MIN;
        end
        return clamp_q((n <<< FRAC) / d);
    endfunction

    // Forward-eliminate one row; on the closing row, back-substitute and queue
    // the solutions from the last row down to row zero.
    task automatic eliminate_row(longint a, longint b, longint c, longint v, bit last_bit);
        int        k;
        bit        closing;
        longint    pivot;
        longint    num;
        longint    x[DEPTH];
        solution_t s;
        k = (rows_taken >= DEPTH) ? DEPTH - 1 : rows_taken;
        closing = last_bit || (k == DEPTH - 1);
        if (k == 0)
        begin
            pivot = b;
            num = v;
        end
        else
        begin
            pivot = clamp_q(b - fx_mul(a, mod_super[k-1]));
            num = clamp_q(v - fx_mul(a, mod_rhs[k-1]));
        end
        mod_super[k] = closing ? 0 : fx_div(c, pivot);
        mod_rhs[k] = fx_div(num, pivot);
        if (!closing)
        begin
            rows_taken = k + 1;
            return;
        end
        x[k] = mod_rhs[k];
        for (int n = k - 1; n >= 0; n--)
            x[n] = clamp_q(mod_rhs[n] - fx_mul(mod_super[n], x[n+1]));
        for (int n = k; n >= 0; n--)
        begin
            s.row_index = n[IDX_W-1:0];
            s.solution = x[n][DATA_W-1:0];
            s.last_out = (n == 0);
            s.singular = pivot_zero_seen;
            s.saturated = clamp_seen;
            expected_solutions.push_back(s);
        end
        rows_taken = 0;
        pivot_zero_seen = 1'b0;
        clamp_seen = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        solution_t want;
        if (!rst_n)
        begin
            expected_solutions.delete();
            rows_taken = 0;
            pivot_zero_seen = 1'b0;
            clamp_seen = 1'b0;
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (sols.valid && sols.ready)
            begin
                if (expected_solutions.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected solution: row %0d value %0d",
                                 sols.row_index, sols.solution);
                end
                else
                begin
                    want = expected_solutions.pop_front();
                    if (want.row_index !== sols.row_index || want.solution !== sols.solution
                        || want.last_out !== sols.last_out || want.singular !== sols.singular
                        || want.saturated !== sols.saturated)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected row %0d x %0d last %b sing %b sat %b,",
                                     want.row_index, want.solution, want.last_out,
                                     want.singular, want.saturated,
                                     " got row %0d x %0d last %b sing %b sat %b",
                                     sols.row_index, sols.solution, sols.last_out,
                                     sols.singular, sols.saturated);
                    end
                end
            end
            if (rows.valid && rows.ready)
                eliminate_row(longint'(rows.sub_diag), longint'(rows.main_diag),
                              longint'(rows.super_diag), longint'(rows.rhs_value),
                              rows.last_row);
            pending = expected_solutions.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
// Top of the tridiagonal solver testbench: clock, reset, row stimulus, output
// back-pressure and the verdict. Depends on tds_pkg, tds_if, tds_checker and the solver.
module testbench;
    import tds_pkg::*;

    localparam int     TOTAL_ROWS = 260;
    localparam longint CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   rows_sent;
    int   phase;
    longint cycles;

    tds_row_if rows ();
    tds_sol_if sols ();

    tridiagonal_system_solver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rows  (rows),
        .sols  (sols)
    );

    tds_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .rows    (rows),
        .sols    (sols),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Phase 0: no stalls; 1: sender idle; 2: receiver stalls; 3: both rarely.
    always @(negedge clk)
    begin
        if (phase == 2)
            sols.ready <= ($urandom_range(99) >= 73);
        else if (phase == 3)
            sols.ready <= ($urandom_range(99) >= 6);
        else
            sols.ready <= 1'b1;
    end

    task automatic send_row(q_t a, q_t b, q_t c, q_t v, bit last_bit);
        int idle_pct;
        idle_pct = (phase == 1) ? 73 : (phase == 3) ? 6 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            rows.valid = 1'b0;
        end
        @(negedge clk);
        rows.valid = 1'b1;
        rows.sub_diag = a;
        rows.main_diag = b;
        rows.super_diag = c;
        rows.rhs_value = v;
        rows.last_row = last_bit;
        do
            @(posedge clk);
        while (!rows.ready);
        rows_sent++;
        phase = (rows_sent * 4) / TOTAL_ROWS;
        if (phase > 3)
            phase = 3;
    endtask

    // Diagonally dominant coefficients keep solutions in range most of the time.
    function automatic q_t small_coef();
        return q_t'($signed($urandom_range(0, 2 * 65536)) - 65536);
    endfunction

    function automatic q_t pivot_coef();
        q_t m;
        m = q_t'($urandom_range(2 * 65536, 8 * 65536));
        return $urandom_range(1) ? m : -m;
    endfunction

    function automatic q_t rhs_coef();
        return q_t'($signed($urandom_range(0, 200 * 65536)) - 100 * 65536);
    endfunction

    task automatic send_system(int n, bit flag_last, int noise_pct);
        bit noisy;
        q_t b;
        for (int i = 0; i < n; i++)
        begin
            noisy = ($urandom_range(99) < noise_pct);
            b = ($urandom_range(39) == 0) ? q_t'(0) : pivot_coef();
            if (noisy)
                send_row($urandom, $urandom, $urandom, $urandom,
                         flag_last && (i == n - 1));
            else
                send_row(small_coef(), b, small_coef(), rhs_coef(),
                         flag_last && (i == n - 1));
        end
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        cycles = 0;
        rows_sent = 0;
        phase = 0;
        rows.valid = 1'b0;
        rows.sub_diag = '0;
        rows.main_diag = '0;
        rows.super_diag = '0;
        rows.rhs_value = '0;
        rows.last_row = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single row with a zero pivot and a negative right-hand side
        send_row(S32_MAX, 0, S32_MIN, S32_MIN, 1'b1);
        // single row with zero pivot and zero numerator
        send_row(S32_MIN, 0, S32_MAX, 0, 1'b1);
        // tiny pivot overflows the quotient
        send_row(0, 1, 0, S32_MAX, 1'b1);
        // extremes in every field across three rows
        send_row(S32_MAX, S32_MIN, S32_MAX, S32_MAX, 1'b0);
        send_row(S32_MIN, S32_MAX, S32_MIN, S32_MIN, 1'b0);
        send_row(S32_MAX, S32_MAX, S32_MAX, S32_MIN, 1'b1);
        // ordinary system: main diagonal of magnitude 4, unit off-diagonals
        send_row(32'sh0001_0000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0008_0000, 1'b0);
        send_row(-32'sh0001_0000, 32'sh0004_0000, -32'sh0001_0000, 32'sh0003_0000, 1'b0);
        send_row(32'sh0001_0000, -32'sh0004_0000, 32'sh0001_0000, -32'sh0002_8000, 1'b1);
        // zero pivot on the second row
        send_row(0, 32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_row(32'sh0002_0000, 32'sh0001_0000, 0, 32'sh0005_0000, 1'b1);

        // full store without a last flag, then one flagged on row 63
        send_system(64, 1'b0, 10);
        send_system(64, 1'b1, 5);

        while (rows_sent < TOTAL_ROWS)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            send_system(n, 1'b1, 15);
        end
        @(negedge clk);
        rows.valid = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
